// ===== rtl/grc_pkg.sv =====
package grc_pkg;

  // build-time configuration
  localparam int NumRays   = 60;
  localparam int MaxSteps  = 8;
  localparam int GridSide  = 8;
  localparam int CellShift = 6;

  // positions are q7, so one cell spans 2^(CellShift+7) lsbs
  localparam int Sh = CellShift + 7;

  localparam int DistW   = 25;
  localparam int SqW     = 50;
  localparam int DivW    = 32;
  localparam int DvsW    = 26;
  localparam int DivCntW = $clog2(DivW);
  localparam int MulW    = 26;
  localparam int KW      = 4;

  localparam logic [DistW-1:0]     FarDist     = 25'd12800000;
  localparam logic [15:0]          RayStep     = 16'd182;
  localparam logic [15:0]          HalfFov     = 16'd5461;
  localparam logic signed [31:0]   TraceLim    = 32'sd8388608;
  localparam logic signed [31:0]   CellSize    = 32'sd1 << Sh;
  localparam logic [9:0]           HeightReset = 10'd272;

  // register indexes
  localparam logic [1:0] CfgIdxMap    = 2'd0;
  localparam logic [1:0] CfgIdxHeight = 2'd1;

  // sine polynomial and shade coefficients
  localparam logic signed [MulW-1:0] PolyC1     = 26'sd102944;
  localparam logic signed [MulW-1:0] PolyC3     = 26'sd42334;
  localparam logic signed [MulW-1:0] PolyC5     = 26'sd4926;
  localparam logic signed [MulW-1:0] ShadeMul   = 26'sd918;
  // ceil(2^32 / 1000), exact for products below 2^22
  localparam logic signed [MulW-1:0] ShadeRecip = 26'sd4294968;

  typedef struct packed {
    logic [15:0] player_x;
    logic [15:0] player_y;
    logic [15:0] player_angle;
  } req_t;

  typedef struct packed {
    logic [5:0] column;
    logic [9:0] wall_height;
    logic [8:0] wall_offset;
    logic [7:0] shade;
    logic       last_column;
  } res_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_FRAME,
    OP_T_INIT,
    OP_T2,
    OP_T3,
    OP_T5,
    OP_ACC_LD,
    OP_ACC_SUB,
    OP_ACC_ADD,
    OP_SIN_ST,
    OP_DIR,
    OP_DIV_RAY,
    OP_FIRST_ST,
    OP_STEP_ST,
    OP_TRACE,
    OP_SQ_LD,
    OP_SQRT_GO,
    OP_DIST_ST,
    OP_FAR_ST,
    OP_DIV_HGT,
    OP_HGT_ST,
    OP_EMIT,
    OP_NEXT
  } op_e;

  typedef enum logic [3:0] {
    M_NONE,
    M_TT,
    M_T2T,
    M_T3T2,
    M_K0T,
    M_K1T3,
    M_K2T5,
    M_FIRST,
    M_STEP,
    M_DX,
    M_DY,
    M_SHD1,
    M_SHD2
  } mul_sel_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SIN,
    ST_DIR,
    ST_PASS,
    ST_FIRST_MUL,
    ST_DIV1,
    ST_WAIT1,
    ST_FIRST_ST,
    ST_DIV2,
    ST_WAIT2,
    ST_STEP_ST,
    ST_TRACE,
    ST_SQ0,
    ST_SQ1,
    ST_SQ2,
    ST_SQW,
    ST_DIST,
    ST_FAR,
    ST_HDIV,
    ST_HWAIT,
    ST_HST,
    ST_SHD1,
    ST_SHD2,
    ST_EMIT,
    ST_NEXT
  } state_e;

  typedef struct packed {
    op_e      op;
    mul_sel_e mul_sel;
    logic     dir;   // 0 horizontal crossings, 1 vertical crossings
    logic     sel;   // 0 sine of r, 1 sine of quarter minus r
  } cmd_t;

  typedef struct packed {
    logic s_zero;
    logic c_zero;
    logic div_done;
    logic sqrt_done;
    logic tr_out;
    logic tr_hit;
    logic k_last;
    logic ray_last;
  } status_t;

endpackage

// ===== rtl/grc_div.sv =====
module grc_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [grc_pkg::DivW-1:0]     dividend_i,
  input  logic signed [grc_pkg::DvsW-1:0]     divisor_i,
  output logic signed [grc_pkg::DivW-1:0]     quotient_o,
  output logic                                done_o
);

  logic [grc_pkg::DivW-1:0]           a_q;
  logic [grc_pkg::DvsW-1:0]           d_q;
  logic [grc_pkg::DvsW-1:0]           rem_q, rem_d;
  logic [grc_pkg::DivCntW-1:0]        cnt_q;
  logic                               busy_q;
  logic                               neg_q;
  logic [grc_pkg::DvsW:0]             trial;
  logic                               ge;

  // one quotient bit per cycle, restoring
  assign trial = {rem_q, a_q[grc_pkg::DivW-1]};
  assign ge    = trial >= {1'b0, d_q};
  assign rem_d = ge ? grc_pkg::DvsW'(trial - {1'b0, d_q}) : trial[grc_pkg::DvsW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= grc_pkg::DivCntW'(grc_pkg::DivW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= dividend_i[grc_pkg::DivW-1] ? grc_pkg::DivW'(-dividend_i) : dividend_i;
      d_q   <= divisor_i[grc_pkg::DvsW-1] ? grc_pkg::DvsW'(-divisor_i) : divisor_i;
      rem_q <= '0;
      neg_q <= dividend_i[grc_pkg::DivW-1] ^ divisor_i[grc_pkg::DvsW-1];
    end else if (busy_q) begin
      rem_q <= rem_d;
      a_q   <= {a_q[grc_pkg::DivW-2:0], ge};
    end
  end

  // truncation toward zero
  assign quotient_o = neg_q ? -$signed(a_q) : $signed(a_q);
  assign done_o     = !busy_q;

endmodule

// ===== rtl/grc_sqrt.sv =====
module grc_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [grc_pkg::SqW-1:0]       value_i,
  output logic [grc_pkg::DistW-1:0]     root_o,
  output logic                          done_o
);

  logic [grc_pkg::SqW-1:0] v_q;
  logic [grc_pkg::SqW-1:0] res_q;
  logic [grc_pkg::SqW-1:0] bit_q;
  logic [grc_pkg::SqW-1:0] rb;

  assign rb = res_q + bit_q;

  // bit walks down from 4^24 by two places a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else if (start_i) begin
      bit_q <= grc_pkg::SqW'(1) << (grc_pkg::SqW - 2);
    end else if (bit_q != '0) begin
      bit_q <= bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= value_i;
      res_q <= '0;
    end else if (bit_q != '0) begin
      if (v_q >= rb) begin
        v_q   <= v_q - rb;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
    end
  end

  assign root_o = res_q[grc_pkg::DistW-1:0];
  assign done_o = bit_q == '0;

endmodule

// ===== rtl/grc_dp.sv =====
module grc_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  grc_pkg::cmd_t     cmd_i,
  output grc_pkg::status_t  status_o,
  input  grc_pkg::req_t     req_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [63:0]       cfg_data_i,
  output logic              result_valid_o,
  output grc_pkg::res_t     result_o
);

  logic [63:0]                        map_q;
  logic [9:0]                         sh_q;
  logic [15:0]                        px_q, py_q, ang_q;
  logic [5:0]                         ray_q;
  logic [16:0]                        t_q, t2_q, t3_q, t5_q, lo_q, hi_q;
  logic signed [39:0]                 acc_q;
  logic signed [17:0]                 s_q, c_q;
  logic signed [2*grc_pkg::MulW-1:0]  mul_q;
  logic signed [31:0]                 x_q, y_q, xs_q, ys_q;
  logic                               adjx_q, adjy_q;
  logic [grc_pkg::KW-1:0]             k_q;
  logic [grc_pkg::SqW-1:0]            sq_q;
  logic [grc_pkg::DistW-1:0]          dh_q, dv_q;
  logic [9:0]                         h_q;
  logic                               valid_q;
  grc_pkg::res_t                      res_q;

  logic                               s_neg, c_neg;
  logic signed [31:0]                 y0h, x0v, cell_h, cell_v, dx, dy, cx, cy;
  logic signed [grc_pkg::MulW-1:0]    mul_a, mul_b;
  logic signed [39:0]                 sv;
  logic [16:0]                        sin_v;
  logic [13:0]                        r;
  logic                               div_go;
  logic signed [grc_pkg::DivW-1:0]    div_dvd, quo;
  logic signed [grc_pkg::DvsW-1:0]    div_dvs;
  logic                               div_done;
  logic                               sqrt_go, sqrt_done;
  logic [grc_pkg::DistW-1:0]          root, dmin;
  logic                               tr_out, in_grid, tr_hit;
  logic [5:0]                         cell_idx;
  logic [9:0]                         h_new;
  logic [19:0]                        shd_raw;
  logic [7:0]                         shade;

  assign s_neg  = s_q[17];
  assign c_neg  = c_q[17];
  assign r      = ang_q[13:0];
  assign y0h    = $signed((32'(py_q >> grc_pkg::Sh) + 32'(!s_neg)) << grc_pkg::Sh);
  assign x0v    = $signed((32'(px_q >> grc_pkg::Sh) + 32'(!c_neg)) << grc_pkg::Sh);
  assign cell_h = s_neg ? -grc_pkg::CellSize : grc_pkg::CellSize;
  assign cell_v = c_neg ? -grc_pkg::CellSize : grc_pkg::CellSize;
  assign dx     = x_q - $signed({16'd0, px_q});
  assign dy     = y_q - $signed({16'd0, py_q});
  assign cx     = x_q - $signed({31'd0, adjx_q});
  assign cy     = y_q - $signed({31'd0, adjy_q});
  assign dmin   = (dv_q < dh_q) ? dv_q : dh_q;

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      grc_pkg::M_TT: begin
        mul_a = $signed({9'd0, t_q});
        mul_b = $signed({9'd0, t_q});
      end
      grc_pkg::M_T2T: begin
        mul_a = $signed({9'd0, t2_q});
        mul_b = $signed({9'd0, t_q});
      end
      grc_pkg::M_T3T2: begin
        mul_a = $signed({9'd0, t3_q});
        mul_b = $signed({9'd0, t2_q});
      end
      grc_pkg::M_K0T: begin
        mul_a = grc_pkg::PolyC1;
        mul_b = $signed({9'd0, t_q});
      end
      grc_pkg::M_K1T3: begin
        mul_a = grc_pkg::PolyC3;
        mul_b = $signed({9'd0, t3_q});
      end
      grc_pkg::M_K2T5: begin
        mul_a = grc_pkg::PolyC5;
        mul_b = $signed({9'd0, t5_q});
      end
      grc_pkg::M_FIRST: begin
        if (cmd_i.dir) begin
          mul_a = grc_pkg::MulW'(x0v - $signed({16'd0, px_q}));
          mul_b = {{8{s_q[17]}}, s_q};
        end else begin
          mul_a = grc_pkg::MulW'(y0h - $signed({16'd0, py_q}));
          mul_b = {{8{c_q[17]}}, c_q};
        end
      end
      grc_pkg::M_STEP: begin
        if (cmd_i.dir) begin
          mul_a = grc_pkg::MulW'(cell_v);
          mul_b = {{8{s_q[17]}}, s_q};
        end else begin
          mul_a = grc_pkg::MulW'(cell_h);
          mul_b = {{8{c_q[17]}}, c_q};
        end
      end
      grc_pkg::M_DX: begin
        mul_a = grc_pkg::MulW'(dx);
        mul_b = grc_pkg::MulW'(dx);
      end
      grc_pkg::M_DY: begin
        mul_a = grc_pkg::MulW'(dy);
        mul_b = grc_pkg::MulW'(dy);
      end
      grc_pkg::M_SHD1: begin
        mul_a = $signed({16'd0, h_q});
        mul_b = grc_pkg::ShadeMul;
      end
      grc_pkg::M_SHD2: begin
        mul_a = $signed({6'd0, mul_q[19:0]});
        mul_b = grc_pkg::ShadeRecip;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // clamp of the quarter sine to [0, 1.0]
  assign sv = acc_q >>> 16;
  always_comb begin
    if (sv > 40'sd65536) begin
      sin_v = 17'd65536;
    end else if (sv < 40'sd0) begin
      sin_v = '0;
    end else begin
      sin_v = sv[16:0];
    end
  end

  // divider feed
  assign div_go  = (cmd_i.op == grc_pkg::OP_DIV_RAY) || (cmd_i.op == grc_pkg::OP_DIV_HGT);
  always_comb begin
    if (cmd_i.op == grc_pkg::OP_DIV_HGT) begin
      div_dvd = $signed(32'({22'd0, sh_q}) << grc_pkg::Sh);
      div_dvs = $signed({1'b0, dmin});
    end else begin
      div_dvd = mul_q[grc_pkg::DivW-1:0];
      div_dvs = cmd_i.dir ? {{8{c_q[17]}}, c_q} : {{8{s_q[17]}}, s_q};
    end
  end

  grc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  assign sqrt_go = cmd_i.op == grc_pkg::OP_SQRT_GO;

  grc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_go),
    .value_i (sq_q + mul_q[grc_pkg::SqW-1:0]),
    .root_o  (root),
    .done_o  (sqrt_done)
  );

  // cell test at the current crossing
  assign tr_out = (x_q <= -grc_pkg::TraceLim) || (x_q >= grc_pkg::TraceLim) ||
                  (y_q <= -grc_pkg::TraceLim) || (y_q >= grc_pkg::TraceLim);
  assign in_grid = !cx[31] && !cy[31] &&
                   ((cx[30:0] >> grc_pkg::Sh) < 31'(grc_pkg::GridSide)) &&
                   ((cy[30:0] >> grc_pkg::Sh) < 31'(grc_pkg::GridSide));
  assign cell_idx = {cy[grc_pkg::Sh+2:grc_pkg::Sh], cx[grc_pkg::Sh+2:grc_pkg::Sh]};
  assign tr_hit = !tr_out && in_grid && map_q[cell_idx];

  // height clamp and shade
  always_comb begin
    if (dmin == '0) begin
      h_new = sh_q;
    end else if (quo > $signed({22'd0, sh_q})) begin
      h_new = sh_q;
    end else begin
      h_new = quo[9:0];
    end
  end
  assign shd_raw = mul_q[51:32];
  assign shade   = (shd_raw > 20'd255) ? 8'd255 : shd_raw[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= '0;
      sh_q  <= grc_pkg::HeightReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == grc_pkg::CfgIdxMap) begin
        map_q <= cfg_data_i;
      end else if (cfg_idx_i == grc_pkg::CfgIdxHeight) begin
        sh_q <= cfg_data_i[9:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.op == grc_pkg::OP_EMIT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_sel != grc_pkg::M_NONE) begin
      mul_q <= mul_a * mul_b;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      grc_pkg::OP_FRAME: begin
        px_q  <= req_i.player_x;
        py_q  <= req_i.player_y;
        ang_q <= req_i.player_angle - grc_pkg::HalfFov;
        ray_q <= '0;
      end
      grc_pkg::OP_T_INIT: begin
        t_q <= cmd_i.sel ? (17'd65536 - {1'b0, r, 2'b00}) : {1'b0, r, 2'b00};
      end
      grc_pkg::OP_T2:      t2_q  <= mul_q[32:16];
      grc_pkg::OP_T3:      t3_q  <= mul_q[32:16];
      grc_pkg::OP_T5:      t5_q  <= mul_q[32:16];
      grc_pkg::OP_ACC_LD:  acc_q <= mul_q[39:0];
      grc_pkg::OP_ACC_SUB: acc_q <= acc_q - mul_q[39:0];
      grc_pkg::OP_ACC_ADD: acc_q <= acc_q + mul_q[39:0];
      grc_pkg::OP_SIN_ST: begin
        if (cmd_i.sel) begin
          hi_q <= sin_v;
        end else begin
          lo_q <= sin_v;
        end
      end
      grc_pkg::OP_DIR: begin
        case (ang_q[15:14])
          2'd0: begin
            s_q <= $signed({1'b0, lo_q});
            c_q <= $signed({1'b0, hi_q});
          end
          2'd1: begin
            s_q <= $signed({1'b0, hi_q});
            c_q <= -$signed({1'b0, lo_q});
          end
          2'd2: begin
            s_q <= -$signed({1'b0, lo_q});
            c_q <= -$signed({1'b0, hi_q});
          end
          default: begin
            s_q <= -$signed({1'b0, hi_q});
            c_q <= $signed({1'b0, lo_q});
          end
        endcase
      end
      grc_pkg::OP_FIRST_ST: begin
        if (cmd_i.dir) begin
          y_q <= $signed({16'd0, py_q}) + quo;
        end else begin
          x_q <= $signed({16'd0, px_q}) + quo;
        end
      end
      grc_pkg::OP_STEP_ST: begin
        k_q <= '0;
        if (cmd_i.dir) begin
          ys_q   <= quo;
          x_q    <= x0v;
          xs_q   <= cell_v;
          adjx_q <= c_neg;
          adjy_q <= 1'b0;
        end else begin
          xs_q   <= quo;
          y_q    <= y0h;
          ys_q   <= cell_h;
          adjx_q <= 1'b0;
          adjy_q <= s_neg;
        end
      end
      grc_pkg::OP_TRACE: begin
        if (!tr_out && !tr_hit) begin
          x_q <= x_q + xs_q;
          y_q <= y_q + ys_q;
          k_q <= k_q + 1'b1;
        end
      end
      grc_pkg::OP_SQ_LD: sq_q <= mul_q[grc_pkg::SqW-1:0];
      grc_pkg::OP_DIST_ST: begin
        if (cmd_i.dir) begin
          dv_q <= root;
        end else begin
          dh_q <= root;
        end
      end
      grc_pkg::OP_FAR_ST: begin
        if (cmd_i.dir) begin
          dv_q <= grc_pkg::FarDist;
        end else begin
          dh_q <= grc_pkg::FarDist;
        end
      end
      grc_pkg::OP_HGT_ST: h_q <= h_new;
      grc_pkg::OP_EMIT: begin
        res_q.column      <= ray_q;
        res_q.wall_height <= h_q;
        res_q.wall_offset <= 9'((sh_q - h_q) >> 1);
        res_q.shade       <= shade;
        res_q.last_column <= ray_q == 6'(grc_pkg::NumRays - 1);
      end
      grc_pkg::OP_NEXT: begin
        ang_q <= ang_q + grc_pkg::RayStep;
        ray_q <= ray_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign status_o.s_zero    = s_q == '0;
  assign status_o.c_zero    = c_q == '0;
  assign status_o.div_done  = div_done;
  assign status_o.sqrt_done = sqrt_done;
  assign status_o.tr_out    = tr_out;
  assign status_o.tr_hit    = tr_hit;
  assign status_o.k_last    = k_q == grc_pkg::KW'(grc_pkg::MaxSteps - 1);
  assign status_o.ray_last  = ray_q == 6'(grc_pkg::NumRays - 1);

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule

// ===== rtl/grc_ctrl.sv =====
module grc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  grc_pkg::status_t  status_i,
  output grc_pkg::cmd_t     cmd_o
);

  grc_pkg::state_e state_q, state_d;
  logic            dir_q, dir_d;
  logic            sel_q, sel_d;
  logic [3:0]      cnt_q, cnt_d;
  logic            skip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= grc_pkg::ST_IDLE;
      dir_q   <= 1'b0;
      sel_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      dir_q   <= dir_d;
      sel_q   <= sel_d;
      cnt_q   <= cnt_d;
    end
  end

  assign skip = dir_q ? status_i.c_zero : status_i.s_zero;

  always_comb begin
    state_d       = state_q;
    dir_d         = dir_q;
    sel_d         = sel_q;
    cnt_d         = cnt_q;
    cmd_o.op      = grc_pkg::OP_NOP;
    cmd_o.mul_sel = grc_pkg::M_NONE;
    cmd_o.dir     = dir_q;
    cmd_o.sel     = sel_q;
    case (state_q)
      grc_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.op = grc_pkg::OP_FRAME;
          sel_d    = 1'b0;
          cnt_d    = '0;
          state_d  = grc_pkg::ST_SIN;
        end
      end
      grc_pkg::ST_SIN: begin
        cnt_d = cnt_q + 1'b1;
        case (cnt_q)
          4'd0: cmd_o.op = grc_pkg::OP_T_INIT;
          4'd1: cmd_o.mul_sel = grc_pkg::M_TT;
          4'd2: cmd_o.op = grc_pkg::OP_T2;
          4'd3: cmd_o.mul_sel = grc_pkg::M_T2T;
          4'd4: cmd_o.op = grc_pkg::OP_T3;
          4'd5: cmd_o.mul_sel = grc_pkg::M_T3T2;
          4'd6: begin
            cmd_o.op      = grc_pkg::OP_T5;
            cmd_o.mul_sel = grc_pkg::M_K0T;
          end
          4'd7: begin
            cmd_o.op      = grc_pkg::OP_ACC_LD;
            cmd_o.mul_sel = grc_pkg::M_K1T3;
          end
          4'd8: begin
            cmd_o.op      = grc_pkg::OP_ACC_SUB;
            cmd_o.mul_sel = grc_pkg::M_K2T5;
          end
          4'd9: cmd_o.op = grc_pkg::OP_ACC_ADD;
          default: begin
            cmd_o.op = grc_pkg::OP_SIN_ST;
            cnt_d    = '0;
            if (sel_q) begin
              state_d = grc_pkg::ST_DIR;
            end else begin
              sel_d = 1'b1;
            end
          end
        endcase
      end
      grc_pkg::ST_DIR: begin
        cmd_o.op = grc_pkg::OP_DIR;
        dir_d    = 1'b0;
        state_d  = grc_pkg::ST_PASS;
      end
      grc_pkg::ST_PASS: begin
        state_d = skip ? grc_pkg::ST_FAR : grc_pkg::ST_FIRST_MUL;
      end
      grc_pkg::ST_FIRST_MUL: begin
        cmd_o.mul_sel = grc_pkg::M_FIRST;
        state_d       = grc_pkg::ST_DIV1;
      end
      grc_pkg::ST_DIV1: begin
        cmd_o.op      = grc_pkg::OP_DIV_RAY;
        cmd_o.mul_sel = grc_pkg::M_STEP;
        state_d       = grc_pkg::ST_WAIT1;
      end
      grc_pkg::ST_WAIT1: begin
        if (status_i.div_done) begin
          state_d = grc_pkg::ST_FIRST_ST;
        end
      end
      grc_pkg::ST_FIRST_ST: begin
        cmd_o.op = grc_pkg::OP_FIRST_ST;
        state_d  = grc_pkg::ST_DIV2;
      end
      grc_pkg::ST_DIV2: begin
        cmd_o.op = grc_pkg::OP_DIV_RAY;
        state_d  = grc_pkg::ST_WAIT2;
      end
      grc_pkg::ST_WAIT2: begin
        if (status_i.div_done) begin
          state_d = grc_pkg::ST_STEP_ST;
        end
      end
      grc_pkg::ST_STEP_ST: begin
        cmd_o.op = grc_pkg::OP_STEP_ST;
        state_d  = grc_pkg::ST_TRACE;
      end
      grc_pkg::ST_TRACE: begin
        cmd_o.op = grc_pkg::OP_TRACE;
        if (status_i.tr_out) begin
          state_d = grc_pkg::ST_FAR;
        end else if (status_i.tr_hit) begin
          state_d = grc_pkg::ST_SQ0;
        end else if (status_i.k_last) begin
          state_d = grc_pkg::ST_FAR;
        end
      end
      grc_pkg::ST_SQ0: begin
        cmd_o.mul_sel = grc_pkg::M_DX;
        state_d       = grc_pkg::ST_SQ1;
      end
      grc_pkg::ST_SQ1: begin
        cmd_o.op      = grc_pkg::OP_SQ_LD;
        cmd_o.mul_sel = grc_pkg::M_DY;
        state_d       = grc_pkg::ST_SQ2;
      end
      grc_pkg::ST_SQ2: begin
        cmd_o.op = grc_pkg::OP_SQRT_GO;
        state_d  = grc_pkg::ST_SQW;
      end
      grc_pkg::ST_SQW: begin
        if (status_i.sqrt_done) begin
          state_d = grc_pkg::ST_DIST;
        end
      end
      grc_pkg::ST_DIST, grc_pkg::ST_FAR: begin
        cmd_o.op = (state_q == grc_pkg::ST_DIST) ? grc_pkg::OP_DIST_ST : grc_pkg::OP_FAR_ST;
        if (dir_q) begin
          state_d = grc_pkg::ST_HDIV;
        end else begin
          dir_d   = 1'b1;
          state_d = grc_pkg::ST_PASS;
        end
      end
      grc_pkg::ST_HDIV: begin
        cmd_o.op = grc_pkg::OP_DIV_HGT;
        state_d  = grc_pkg::ST_HWAIT;
      end
      grc_pkg::ST_HWAIT: begin
        if (status_i.div_done) begin
          state_d = grc_pkg::ST_HST;
        end
      end
      grc_pkg::ST_HST: begin
        cmd_o.op = grc_pkg::OP_HGT_ST;
        state_d  = grc_pkg::ST_SHD1;
      end
      grc_pkg::ST_SHD1: begin
        cmd_o.mul_sel = grc_pkg::M_SHD1;
        state_d       = grc_pkg::ST_SHD2;
      end
      grc_pkg::ST_SHD2: begin
        cmd_o.mul_sel = grc_pkg::M_SHD2;
        state_d       = grc_pkg::ST_EMIT;
      end
      grc_pkg::ST_EMIT: begin
        cmd_o.op = grc_pkg::OP_EMIT;
        state_d  = grc_pkg::ST_NEXT;
      end
      grc_pkg::ST_NEXT: begin
        cmd_o.op = grc_pkg::OP_NEXT;
        sel_d    = 1'b0;
        cnt_d    = '0;
        state_d  = status_i.ray_last ? grc_pkg::ST_IDLE : grc_pkg::ST_SIN;
      end
      default: begin
        state_d = grc_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = state_q != grc_pkg::ST_IDLE;

endmodule

// ===== rtl/grid_raycast_column_heights_top.sv =====
// Grid ray caster, column heights. Pulse start while busy is low to hand in
// one frame word (player position and view angle); the block then casts 60
// rays one degree apart, starting 30 degrees left of the view, and puts out
// one result word per ray on result_o, flagged by result_valid_o for exactly
// one cycle. The receiver cannot stall the block, so it must take every
// strobed word as it comes; the last word of a frame has last_column set.
// The time a ray takes is set by the serial divider (one quotient bit a
// cycle, up to five divisions per ray) and the serial square root (one root
// bit a cycle, one per wall hit), together with the sine polynomial and the
// grid walk over the cells that the ray crosses. Configuration (wall bitmap,
// screen height) is written through cfg_we_i / cfg_idx_i / cfg_data_i and
// should only change while busy is low.
module grid_raycast_column_heights_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  // frame request
  input  logic           start,
  output logic           busy,
  input  grc_pkg::req_t  req_i,
  // configuration writes
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [63:0]    cfg_data_i,
  // one word per column
  output logic           result_valid_o,
  output grc_pkg::res_t  result_o
);

  grc_pkg::cmd_t    cmd;
  grc_pkg::status_t status;

  // sequencer: sine, two grid walks, height and shade per ray
  grc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // working registers, shared multiplier, divider and square root
  grc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .req_i          (req_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ===== bench/grid_raycast_column_heights_top_tb.sv =====
`timescale 1ns / 1ps

module grid_raycast_column_heights_top_tb;

  // spare register indexes, writes there must leave both registers alone
  localparam logic [1:0] CfgIdxSpareA = 2'd2;
  localparam logic [1:0] CfgIdxSpareB = 2'd3;
  localparam int NoTypedHeight = -1;
  localparam int RandomFrames  = 132;
  localparam int SettleCycles  = 400;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  grc_pkg::req_t   req_i;
  logic            cfg_we_i;
  logic [1:0]      cfg_idx_i;
  logic [63:0]     cfg_data_i;
  logic            result_valid_o;
  grc_pkg::res_t   result_o;

  grid_raycast_column_heights_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the two registers as the predictor sees them
  logic [63:0] wall_map;
  logic [9:0]  scr_height;

  grc_pkg::res_t expected_columns[$];
  int            err_cnt;

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // column height predictor
  // ---------------------------------------------------------------------------

  // sine over one quarter turn, r in binary angle units 0..16384, result q16
  function automatic longint quarter_sin(input longint r);
    longint t, t2, t3, t5, v;
    t  = r * 4;
    t2 = (t * t) >>> 16;
    t3 = (t2 * t) >>> 16;
    t5 = (t3 * t2) >>> 16;
    v  = (longint'(102944) * t - longint'(42334) * t3 + longint'(4926) * t5) >>> 16;
    if (v > 65536) v = 65536;
    if (v < 0) v = 0;
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned res, bit_w;
    res   = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v   = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  // walk one family of grid crossings, distance to the first wall or far
  function automatic longint walk_crossings(input longint x, input longint y,
                                            input longint xs, input longint ys,
                                            input longint adjx, input longint adjy,
                                            input longint px, input longint py);
    longint cx, cy, mx, my, dx, dy;
    longint unsigned sq;
    for (int k = 0; k < grc_pkg::MaxSteps; k++) begin
      if (x <= -grc_pkg::TraceLim || x >= grc_pkg::TraceLim ||
          y <= -grc_pkg::TraceLim || y >= grc_pkg::TraceLim) break;
      // negative stepping looks one lsb before the line
      cx = x - adjx;
      cy = y - adjy;
      if (cx >= 0 && cy >= 0) begin
        mx = cx >>> grc_pkg::Sh;
        my = cy >>> grc_pkg::Sh;
        if (mx < grc_pkg::GridSide && my < grc_pkg::GridSide && wall_map[my * 8 + mx]) begin
          dx = x - px;
          dy = y - py;
          sq = longint'(dx * dx) + longint'(dy * dy);
          return longint'(floor_sqrt(sq));
        end
      end
      x += xs;
      y += ys;
    end
    return longint'(grc_pkg::FarDist);
  endfunction

  function automatic grc_pkg::res_t column_word(input int col, input longint unsigned h);
    grc_pkg::res_t w;
    longint unsigned shd;
    shd = h * 918 / 1000;
    if (shd > 255) shd = 255;
    w.column      = 6'(col);
    w.wall_height = 10'(h);
    w.wall_offset = 9'((longint'(scr_height) - longint'(h)) / 2);
    w.shade       = 8'(shd);
    w.last_column = (col == grc_pkg::NumRays - 1);
    return w;
  endfunction

  task automatic predict_frame(input grc_pkg::req_t rq);
    logic [15:0] ang;
    longint px, py, s, c, lo, hi, cell_sz, row, col, y0, x0, stp, adj;
    longint dh, dv, near_d;
    longint unsigned h;
    cell_sz = longint'(1) << grc_pkg::Sh;
    px      = rq.player_x;
    py      = rq.player_y;
    ang     = rq.player_angle - grc_pkg::HalfFov;
    for (int r = 0; r < grc_pkg::NumRays; r++) begin
      lo = quarter_sin(ang[13:0]);
      hi = quarter_sin(16384 - longint'(ang[13:0]));
      case (ang[15:14])
        2'd0: begin s = lo;  c = hi;  end
        2'd1: begin s = hi;  c = -lo; end
        2'd2: begin s = -lo; c = -hi; end
        default: begin s = -hi; c = lo; end
      endcase
      dh = grc_pkg::FarDist;
      dv = grc_pkg::FarDist;
      // axis-aligned rays skip the degenerate crossing family
      if (s != 0) begin
        row = py >>> grc_pkg::Sh;
        if (s > 0) begin y0 = (row + 1) * cell_sz; stp = cell_sz;  adj = 0; end
        else       begin y0 = row * cell_sz;       stp = -cell_sz; adj = 1; end
        dh = walk_crossings(px + ((y0 - py) * c) / s, y0, (stp * c) / s, stp,
                            0, adj, px, py);
      end
      if (c != 0) begin
        col = px >>> grc_pkg::Sh;
        if (c > 0) begin x0 = (col + 1) * cell_sz; stp = cell_sz;  adj = 0; end
        else       begin x0 = col * cell_sz;       stp = -cell_sz; adj = 1; end
        dv = walk_crossings(x0, py + ((x0 - px) * s) / c, stp, (stp * s) / c,
                            adj, 0, px, py);
      end
      // ties go to the horizontal hit
      near_d = (dv < dh) ? dv : dh;
      if (near_d == 0) h = scr_height;
      else h = (longint'(scr_height) << grc_pkg::Sh) / near_d;
      if (h > scr_height) h = scr_height;
      expected_columns.push_back(column_word(r, h));
      ang = ang + grc_pkg::RayStep;
    end
  endtask

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == grc_pkg::CfgIdxMap) wall_map = data;
    else if (idx == grc_pkg::CfgIdxHeight) scr_height = data[9:0];
    @(posedge clk_i);
  endtask

  // wait for every expected word, then let the block settle before a write
  task automatic drain;
    while (expected_columns.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [63:0] map, input logic [9:0] hgt);
    drain();
    write_reg(grc_pkg::CfgIdxMap, map);
    // junk above bit 9 must be masked off
    write_reg(grc_pkg::CfgIdxHeight, {$urandom, 22'($urandom), hgt});
  endtask

  // hand in one frame word; typed_h >= 0 gives every column that height
  task automatic send_frame(input grc_pkg::req_t rq, input int typed_h);
    start <= 1'b1;
    req_i <= rq;
    // busy only moves on a rising edge, so its value mid-cycle is the one sampled
    do @(negedge clk_i); while (busy !== 1'b0);
    @(posedge clk_i);
    start <= 1'b0;
    if (typed_h == NoTypedHeight) begin
      predict_frame(rq);
    end else begin
      for (int r = 0; r < grc_pkg::NumRays; r++)
        expected_columns.push_back(column_word(r, typed_h));
    end
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // result checker, the receiver cannot stall so every strobe is a word
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    grc_pkg::res_t exp_w;
    if (rst_ni && result_valid_o) begin
      if (expected_columns.size() == 0) begin
        report_mismatch($sformatf("unexpected word %p", result_o));
      end else begin
        exp_w = expected_columns.pop_front();
        if (result_o.column !== exp_w.column)
          report_mismatch($sformatf("column %0d exp %0d", result_o.column, exp_w.column));
        if (result_o.wall_height !== exp_w.wall_height)
          report_mismatch($sformatf("col %0d wall_height %0d exp %0d", exp_w.column,
                                    result_o.wall_height, exp_w.wall_height));
        if (result_o.wall_offset !== exp_w.wall_offset)
          report_mismatch($sformatf("col %0d wall_offset %0d exp %0d", exp_w.column,
                                    result_o.wall_offset, exp_w.wall_offset));
        if (result_o.shade !== exp_w.shade)
          report_mismatch($sformatf("col %0d shade %0d exp %0d", exp_w.column,
                                    result_o.shade, exp_w.shade));
        if (result_o.last_column !== exp_w.last_column)
          report_mismatch($sformatf("col %0d last_column %0b exp %0b", exp_w.column,
                                    result_o.last_column, exp_w.last_column));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // directed table
  // ---------------------------------------------------------------------------

  typedef struct {
    logic [63:0] map;
    logic [9:0]  hgt;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] ang;
    int          typed_h;
  } frame_row_t;

  localparam logic [63:0] MapFull   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MapBorder = 64'hFF81_8181_8181_81FF;
  localparam logic [63:0] MapCheck  = 64'hAA55_AA55_AA55_AA55;

  frame_row_t dir_rows[] = '{
    // empty map, nothing is ever hit, so every height is zero
    '{64'd0,     10'd272,  16'h0000, 16'h0000, 16'h0000, 0},
    '{64'd0,     10'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0},
    '{64'd0,     10'd1,    16'h8000, 16'h8000, 16'h4000, 0},
    // standing on a grid line looking down into a full map: zero distance
    '{MapFull,   10'd272,  16'd8192, 16'd8192, 16'hC000, 272},
    '{MapFull,   10'd1023, 16'd8192, 16'd8192, 16'hC000, 1023},
    '{MapFull,   10'd1,    16'd8192, 16'd8192, 16'hC000, 1},
    // first ray exactly along an axis, one crossing family skipped
    '{MapBorder, 10'd272,  16'h8000, 16'h8000, 16'd5461, NoTypedHeight},
    '{MapBorder, 10'd272,  16'h8000, 16'h8000, 16'd21845, NoTypedHeight},
    '{MapBorder, 10'd272,  16'h8000, 16'h8000, 16'd38229, NoTypedHeight},
    '{MapBorder, 10'd272,  16'h8000, 16'h8000, 16'd54613, NoTypedHeight},
    // corners and edges of the world, rays leaving the grid, then inner positions
    '{MapBorder, 10'd1023, 16'h0000, 16'h0000, 16'h0000, NoTypedHeight},
    '{MapBorder, 10'd1023, 16'hFFFF, 16'hFFFF, 16'h8000, NoTypedHeight},
    '{MapCheck,  10'd272,  16'h0000, 16'hFFFF, 16'hE000, NoTypedHeight},
    '{MapCheck,  10'd500,  16'hFFFF, 16'h0000, 16'h6000, NoTypedHeight},
    '{MapFull,   10'd272,  16'h1234, 16'h5678, 16'h2000, NoTypedHeight},
    '{MapFull,   10'd1,    16'h7FFF, 16'h2000, 16'hFFFF, NoTypedHeight},
    '{MapCheck,  10'd1023, 16'h4040, 16'h4040, 16'h0001, NoTypedHeight}
  };

  function automatic logic [63:0] random_map(input int style);
    logic [63:0] m;
    m = {$urandom, $urandom};
    case (style)
      0: m = m | {$urandom, $urandom};
      1: m = m & {$urandom, $urandom};
      2: m = m | MapBorder;
      default: ;
    endcase
    return m;
  endfunction

  function automatic logic [9:0] random_height;
    case ($urandom_range(3))
      0: return 10'd1;
      1: return 10'd1023;
      2: return 10'd272;
      default: return 10'($urandom_range(1023, 1));
    endcase
  endfunction

  int idle_pct[4] = '{0, 55, 55, 9};

  initial begin
    grc_pkg::req_t rq;
    clk_i      = 1'b0;
    rst_ni     = 1'b0;
    start      = 1'b0;
    req_i      = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = grc_pkg::CfgIdxMap;
    cfg_data_i = '0;
    err_cnt    = 0;
    wall_map   = '0;
    scr_height = grc_pkg::HeightReset;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one frame on the reset values, empty map gives zero height
    rq = '{player_x: 16'h4000, player_y: 16'h4000, player_angle: 16'h1000};
    send_frame(rq, 0);

    // spare indexes must not disturb anything
    drain();
    write_reg(CfgIdxSpareA, MapFull);
    write_reg(CfgIdxSpareB, 64'd5);
    send_frame(rq, 0);

    foreach (dir_rows[i]) begin
      set_config(dir_rows[i].map, dir_rows[i].hgt);
      rq = '{player_x: dir_rows[i].px, player_y: dir_rows[i].py,
             player_angle: dir_rows[i].ang};
      send_frame(rq, dir_rows[i].typed_h);
    end

    // random frames in four phases, each with its own map, height and idling
    for (int ph = 0; ph < 4; ph++) begin
      set_config(random_map(ph), random_height());
      for (int n = 0; n < RandomFrames / 4; n++) begin
        if ($urandom_range(99) < idle_pct[ph])
          repeat ($urandom_range(60, 1)) @(posedge clk_i);
        // hold off once until the block has delivered everything
        if (ph == 1 && n == 10)
          while (expected_columns.size() != 0) @(posedge clk_i);
        // a few frames change the map mid phase after a full drain
        if (n % 12 == 11)
          set_config(random_map($urandom_range(3)), scr_height);
        rq = '{player_x: 16'($urandom), player_y: 16'($urandom),
               player_angle: 16'($urandom)};
        send_frame(rq, NoTypedHeight);
      end
    end

    while (expected_columns.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // timeout well beyond the run of about 150 frames
  initial begin
    #(200_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
